FILE: hw/rtl/tsa_pkg.sv
// Shared types and codes for the timestamp sequence aligner.
package tsa_pkg;

  localparam int TimeWidth  = 63;
  localparam int ValueWidth = 64;
  localparam int DistWidth  = 32;

  typedef logic [1:0] op_t;
  localparam op_t OpAppendFirst  = 2'd0;
  localparam op_t OpAppendSecond = 2'd1;
  localparam op_t OpRun          = 2'd2;

  typedef logic cfg_index_t;
  localparam cfg_index_t CfgMaxDistance = 1'b0;
  localparam cfg_index_t CfgFillValue   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAIR_RD,
    ST_PAIR_EV,
    ST_MRG_PRD,
    ST_MRG_PLD,
    ST_MRG_RD,
    ST_MRG_EMIT,
    ST_MRG_END
  } state_t;

endpackage

FILE: hw/rtl/timestamp_sequence_aligner.sv
// Timestamp sequence aligner: loads two event stores and emits aligned rows on a run.
//
// Append transactions (tuser 0 or 1) are taken one per cycle while idle and write one
// entry of the first or second store; a store holding SEQ_DEPTH events ignores further
// appends. A run transaction (tuser 2) blocks the input while the block walks the stores:
// the pairing pass visits each candidate entry with a memory read state and then a
// compare state, and as the other store resumes just after the chosen candidate, entries
// can be visited again, up to about n*m visits in the worst case. The row pass has a read
// state and an emit state per output row, plus a pair-table read for each pair, as each
// store has a single read port. Rows leave through an output register, and the last row
// carries tlast. A run with both stores empty emits nothing. Both stores are empty again
// after every run.
module timestamp_sequence_aligner
  import tsa_pkg::*;
#(
  parameter int SEQ_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [127:0]          s_tdata,   // event_time[62:0], event_value[126:63], zero pad
  input  logic [1:0]            s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata,   // value_first[63:0], value_second[127:64]
  output logic                  m_tlast,   // last_row
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [ValueWidth-1:0] cfg_data
);

  localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CW = $clog2(SEQ_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(SEQ_DEPTH);

  // stores
  logic [TimeWidth-1:0]  first_times   [SEQ_DEPTH];
  logic [ValueWidth-1:0] first_values  [SEQ_DEPTH];
  logic [TimeWidth-1:0]  second_times  [SEQ_DEPTH];
  logic [ValueWidth-1:0] second_values [SEQ_DEPTH];
  logic [AW-1:0]         pair_first_index  [SEQ_DEPTH];
  logic [AW-1:0]         pair_second_index [SEQ_DEPTH];

  logic [TimeWidth-1:0]  ft_rd, st_rd;
  logic [ValueWidth-1:0] fv_rd, sv_rd;
  logic [AW-1:0]         pf_rd, ps_rd;

  state_t state, state_next;

  logic [DistWidth-1:0]  max_distance;
  logic [ValueWidth-1:0] pad_value;
  logic [CW-1:0] first_count, second_count, pair_count;
  logic          swap, first_cand, has_pair;
  logic [CW-1:0] nd, no, i, j, bj, k, a, b, ea, eb;
  logic [TimeWidth-1:0] best;

  logic [ValueWidth-1:0] pend_first, pend_second;
  logic                  pend_valid;

  op_t op;
  wire accept   = s_tvalid & s_tready;
  wire out_free = !m_tvalid || m_tready;

  assign op = s_tuser;

  // address selection
  logic [CW-1:0] f_addr, s_addr;
  always_comb begin
    s_tready = 1'b0;
    f_addr   = a;
    s_addr   = b;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        f_addr   = first_count;
        s_addr   = second_count;
      end
      ST_PAIR_RD, ST_PAIR_EV: begin
        f_addr = swap ? j : i;
        s_addr = swap ? i : j;
      end
      default: begin
        f_addr = a;
        s_addr = b;
      end
    endcase
  end

  // pairing evaluation
  logic [TimeWidth-1:0] dt, ot, gap, cur_best;
  logic [CW-1:0]        cur_bj, j_inc, i_inc, j_after;
  logic                 ot_le, pair_we, inner_go, outer_go;
  always_comb begin
    dt       = swap ? st_rd : ft_rd;
    ot       = swap ? ft_rd : st_rd;
    gap      = (dt >= ot) ? dt - ot : ot - dt;
    ot_le    = ot <= dt;
    cur_best = first_cand ? gap : best;
    cur_bj   = first_cand ? j : bj;
    if (ot_le && !first_cand && gap < best) begin
      cur_best = gap;
      cur_bj   = j;
    end
    j_inc    = j + 1'b1;
    i_inc    = i + 1'b1;
    j_after  = cur_bj + 1'b1;
    inner_go = ot_le && (j_inc < no);
    pair_we  = (state == ST_PAIR_EV) && !inner_go &&
               (cur_best <= {{(TimeWidth-DistWidth){1'b0}}, max_distance});
    outer_go = (i_inc < nd) && (j_after < no);
  end

  // merge evaluation
  logic take_f, take_s, span_done, row_gen, can_push;
  logic [ValueWidth-1:0] row_first, row_second;
  always_comb begin
    take_f = 1'b0;
    take_s = 1'b0;
    if (a < ea && b < eb) begin
      take_f = ft_rd <= st_rd;
      take_s = !(ft_rd <= st_rd);
    end else if (a < ea) begin
      take_f = 1'b1;
    end else if (b < eb) begin
      take_s = 1'b1;
    end
    span_done  = !take_f && !take_s;
    row_gen    = !span_done || has_pair;
    can_push   = !pend_valid || out_free;
    row_first  = take_s ? pad_value : fv_rd;
    row_second = take_f ? pad_value : sv_rd;
  end

  // staged row moves to the output register
  wire out_load = pend_valid && can_push &&
                  (((state == ST_MRG_EMIT) && row_gen) || (state == ST_MRG_END));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == OpRun) begin
          if (first_count == '0 || second_count == '0) state_next = ST_MRG_PRD;
          else state_next = ST_PAIR_RD;
        end
      end
      ST_PAIR_RD: state_next = ST_PAIR_EV;
      ST_PAIR_EV: begin
        if (inner_go || outer_go) state_next = ST_PAIR_RD;
        else state_next = ST_MRG_PRD;
      end
      ST_MRG_PRD: state_next = ST_MRG_PLD;
      ST_MRG_PLD: state_next = ST_MRG_RD;
      ST_MRG_RD:  state_next = ST_MRG_EMIT;
      ST_MRG_EMIT: begin
        if (!(row_gen && !can_push)) begin
          if (!span_done) state_next = ST_MRG_RD;
          else if (has_pair) state_next = ST_MRG_PRD;
          else state_next = ST_MRG_END;
        end
      end
      ST_MRG_END: if (can_push) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && op == OpAppendFirst && first_count < Depth) begin
      first_times[f_addr[AW-1:0]]  <= s_tdata[TimeWidth-1:0];
      first_values[f_addr[AW-1:0]] <= s_tdata[TimeWidth+ValueWidth-1:TimeWidth];
    end
    ft_rd <= first_times[f_addr[AW-1:0]];
    fv_rd <= first_values[f_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && op == OpAppendSecond && second_count < Depth) begin
      second_times[s_addr[AW-1:0]]  <= s_tdata[TimeWidth-1:0];
      second_values[s_addr[AW-1:0]] <= s_tdata[TimeWidth+ValueWidth-1:TimeWidth];
    end
    st_rd <= second_times[s_addr[AW-1:0]];
    sv_rd <= second_values[s_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_first_index[pair_count[AW-1:0]]  <= swap ? cur_bj[AW-1:0] : i[AW-1:0];
      pair_second_index[pair_count[AW-1:0]] <= swap ? i[AW-1:0] : cur_bj[AW-1:0];
    end
    pf_rd <= pair_first_index[k[AW-1:0]];
    ps_rd <= pair_second_index[k[AW-1:0]];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= DistWidth'(1);
      pad_value    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMaxDistance: max_distance <= cfg_data[DistWidth-1:0];
        CfgFillValue:   pad_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      pair_count   <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OpAppendFirst:  if (first_count < Depth) first_count <= first_count + 1'b1;
              OpAppendSecond: if (second_count < Depth) second_count <= second_count + 1'b1;
              OpRun: begin
                swap       <= second_count < first_count;
                nd         <= (second_count < first_count) ? second_count : first_count;
                no         <= (second_count < first_count) ? first_count : second_count;
                i          <= '0;
                j          <= '0;
                first_cand <= 1'b1;
                pair_count <= '0;
                k          <= '0;
                a          <= '0;
                b          <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_PAIR_EV: begin
          if (pair_we) pair_count <= pair_count + 1'b1;
          if (inner_go) begin
            best       <= cur_best;
            bj         <= cur_bj;
            j          <= j_inc;
            first_cand <= 1'b0;
          end else begin
            i          <= i_inc;
            j          <= j_after;
            first_cand <= 1'b1;
          end
        end
        ST_MRG_PLD: begin
          has_pair <= k < pair_count;
          if (k < pair_count) begin
            ea <= CW'(pf_rd);
            eb <= CW'(ps_rd);
          end else begin
            ea <= first_count;
            eb <= second_count;
          end
        end
        ST_MRG_EMIT: begin
          if (row_gen && can_push) begin
            if (pend_valid) begin
              m_tdata  <= {pend_second, pend_first};
              m_tlast  <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_first  <= row_first;
            pend_second <= row_second;
          end
          if (!(row_gen && !can_push)) begin
            if (take_f) a <= a + 1'b1;
            if (take_s) b <= b + 1'b1;
            if (span_done && has_pair) begin
              a <= a + 1'b1;
              b <= b + 1'b1;
              k <= k + 1'b1;
            end
          end
        end
        ST_MRG_END: begin
          if (can_push) begin
            if (pend_valid) begin
              m_tdata  <= {pend_second, pend_first};
              m_tlast  <= 1'b1;
            end
            pend_valid   <= 1'b0;
            first_count  <= '0;
            second_count <= '0;
            pair_count   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("row left pending in idle");

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    (first_count <= Depth) && (second_count <= Depth))
    else $error("store count beyond depth");

  a_pairs_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIR_EV) |-> (pair_count <= i) && (i < nd) && (j < no))
    else $error("pairing indices out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRG_END && state_next == ST_IDLE) |=>
      (first_count == '0) && (second_count == '0))
    else $error("stores not cleared after run");
`endif

endmodule

FILE: bench/tb_top.sv
// Timestamp sequence aligner testbench: directed and random loads and runs checked versus a local predictor.
module tb_top;
  import tsa_pkg::*;

  localparam int Depth = 32;
  localparam op_t OpSpare = 2'd3;

  typedef struct packed {
    op_t                   op;
    logic [TimeWidth-1:0]  t;
    logic [ValueWidth-1:0] v;
  } load_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] vf;
    logic [ValueWidth-1:0] vs;
    logic                  last;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [ValueWidth-1:0] cfg_data = '0;

  timestamp_sequence_aligner #(.SEQ_DEPTH(Depth)) dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [31:0]           pr_maxd = 32'd1;
  logic [ValueWidth-1:0] pr_fill = '0;
  logic [TimeWidth-1:0]  ft[Depth], st[Depth];
  logic [ValueWidth-1:0] fv[Depth], sv[Depth];
  int fcnt = 0, scnt = 0;

  load_item_t pending_items[$];
  row_t       expected_rows[$];
  bit  failed = 0;
  bit  drain_mode = 0;
  bit  in_done = 0;
  bit  hold_req = 0;
  bit  hold_on = 0;

  function automatic logic [TimeWidth-1:0] gap_of(logic [TimeWidth-1:0] a,
                                                   logic [TimeWidth-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic push_row(logic [ValueWidth-1:0] a, logic [ValueWidth-1:0] b);
    row_t r;
    r.vf = a; r.vs = b; r.last = 0;
    expected_rows.insert(expected_rows.size(), r);
  endtask

  task automatic queue_item(load_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic merge_rows(inout int a, inout int b, input int ea, input int eb);
    while (a < ea || b < eb) begin
      if (a < ea && (b >= eb || ft[a] <= st[b])) begin
        push_row(fv[a], pr_fill); a++;
      end else begin
        push_row(pr_fill, sv[b]); b++;
      end
    end
  endtask

  task automatic predict_alignment(load_item_t it);
    int pf[$], ps[$];
    int nd, no, i, j, bj, a, b, k, start;
    bit swap;
    logic [TimeWidth-1:0] best, d, tdrv;
    case (it.op)
      OpAppendFirst: if (fcnt < Depth) begin
        ft[fcnt] = it.t; fv[fcnt] = it.v; fcnt++;
      end
      OpAppendSecond: if (scnt < Depth) begin
        st[scnt] = it.t; sv[scnt] = it.v; scnt++;
      end
      OpRun: begin
        start = expected_rows.size();
        swap = scnt < fcnt;
        nd = swap ? scnt : fcnt;
        no = swap ? fcnt : scnt;
        i = 0; j = 0;
        while (i < nd && j < no) begin
          tdrv = swap ? st[i] : ft[i];
          best = gap_of(tdrv, swap ? ft[j] : st[j]);
          bj = j;
          while (j < no && (swap ? ft[j] : st[j]) <= tdrv) begin
            d = gap_of(tdrv, swap ? ft[j] : st[j]);
            if (d < best) begin
              best = d; bj = j;
            end
            j++;
          end
          if (best <= {31'd0, pr_maxd}) begin
            pf.insert(pf.size(), swap ? bj : i);
            ps.insert(ps.size(), swap ? i : bj);
          end
          i++;
          j = bj + 1;
        end
        a = 0; b = 0;
        for (k = 0; k < pf.size(); k++) begin
          merge_rows(a, b, pf[k], ps[k]);
          push_row(fv[pf[k]], sv[ps[k]]);
          a = pf[k] + 1; b = ps[k] + 1;
        end
        merge_rows(a, b, fcnt, scnt);
        if (expected_rows.size() > start)
          expected_rows[expected_rows.size()-1].last = 1;
        fcnt = 0; scnt = 0;
      end
      default: ;
    endcase
  endtask

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_done <= s_tvalid && s_tready;
  end

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_done) begin
        // hold current item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 0;
      end else if (pending_items.size() > 0) begin
        load_item_t it;
        it = pending_items.pop_front();
        s_tvalid <= 1;
        s_tuser <= it.op;
        s_tdata <= {1'b0, it.v, it.t};
        predict_alignment(it);
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // long receiver hold-off, counted here once requested
  initial begin
    wait (hold_req);
    hold_on = 1;
    repeat (400) @(negedge clk);
    hold_on = 0;
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_on) begin
      m_tready <= 0;
    end else if (drain_mode || stall_phase[7:6] == 2'd0) begin
      m_tready <= 1;
    end else begin
      m_tready <= (stall_phase % 5 != 2) && ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row vf=%h vs=%h last=%b", $time,
                 m_tdata[63:0], m_tdata[127:64], m_tlast);
        failed <= 1;
      end else begin
        row_t e;
        e = expected_rows.pop_front();
        if (m_tdata[63:0] !== e.vf) begin
          $display("%0t: value_first exp %h got %h", $time, e.vf, m_tdata[63:0]);
          failed <= 1;
        end
        if (m_tdata[127:64] !== e.vs) begin
          $display("%0t: value_second exp %h got %h", $time, e.vs, m_tdata[127:64]);
          failed <= 1;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last_row exp %b got %b", $time, e.last, m_tlast);
          failed <= 1;
        end
      end
    end
  end

  function automatic load_item_t mk(op_t op, logic [TimeWidth-1:0] t,
                                    logic [ValueWidth-1:0] v);
    load_item_t it;
    it.op = op; it.t = t; it.v = v;
    return it;
  endfunction

  function automatic logic [ValueWidth-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || expected_rows.size() > 0)
      @(posedge clk);
    // run with no rows may still be busy
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [ValueWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CfgMaxDistance) pr_maxd = val[31:0];
    else pr_fill = val;
  endtask

  // one sorted pair of sequences of the given sizes with random gaps, then a run
  task automatic queue_sequences(int nf, int ns, int step);
    logic [TimeWidth-1:0] tf, ts;
    int k;
    tf = TimeWidth'($urandom_range(0, 50));
    ts = TimeWidth'($urandom_range(0, 50));
    for (k = 0; k < nf || k < ns; k++) begin
      if (k < nf) begin
        queue_item(mk(OpAppendFirst, tf, rnd64()));
        tf += TimeWidth'($urandom_range(0, step));
      end
      if (k < ns) begin
        queue_item(mk(OpAppendSecond, ts, rnd64()));
        ts += TimeWidth'($urandom_range(0, step));
      end
    end
    if ($urandom_range(0, 9) == 0)
      queue_item(mk(OpSpare, TimeWidth'(rnd64()), rnd64()));
    queue_item(mk(OpRun, TimeWidth'(rnd64()), rnd64()));
  endtask

  logic [TimeWidth-1:0] tmax;

  initial begin
    tmax = {TimeWidth{1'b1}};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty run, extremes, equal times, unused code, full store
    queue_item(mk(OpRun, '0, '0));
    queue_item(mk(OpAppendFirst, '0, 64'h8000_0000_0000_0000));
    queue_item(mk(OpAppendSecond, '0, 64'h7fff_ffff_ffff_ffff));
    queue_item(mk(OpAppendFirst, tmax, '1));
    queue_item(mk(OpAppendSecond, tmax - 1, '0));
    queue_item(mk(OpSpare, tmax, '1));
    queue_item(mk(OpRun, tmax, '1));
    queue_item(mk(OpAppendFirst, 63'd5, 64'd1));
    queue_item(mk(OpRun, '0, '0));
    queue_item(mk(OpAppendSecond, 63'd5, 64'd2));
    queue_item(mk(OpAppendSecond, 63'd9, 64'd3));
    queue_item(mk(OpRun, '0, '0));
    wait_idle();

    write_cfg(CfgMaxDistance, 64'd0);
    write_cfg(CfgFillValue, 64'h8000_0000_0000_0000);
    queue_item(mk(OpAppendFirst, 63'd7, 64'd11));
    queue_item(mk(OpAppendSecond, 63'd7, 64'd12));
    queue_item(mk(OpAppendSecond, 63'd8, 64'd13));
    queue_item(mk(OpRun, '0, '0));
    for (int k = 0; k < Depth + 2; k++)
      queue_item(mk(OpAppendFirst, TimeWidth'(k), rnd64()));
    queue_item(mk(OpAppendSecond, 63'd3, 64'd99));
    queue_item(mk(OpRun, '0, '0));
    wait_idle();

    // long receiver hold-off while loads and a big run queue up
    write_cfg(CfgMaxDistance, 64'hffff_ffff);
    write_cfg(CfgFillValue, 64'h7fff_ffff_ffff_ffff);
    queue_sequences(Depth, Depth, 3);
    queue_sequences(6, 9, 5);
    @(negedge clk);
    hold_req = 1;
    wait_idle();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph % 4)
        0: write_cfg(CfgMaxDistance, 64'd1);
        1: write_cfg(CfgMaxDistance, ValueWidth'($urandom_range(0, 20)));
        2: write_cfg(CfgMaxDistance, 64'hffff_ffff);
        default: write_cfg(CfgMaxDistance, ValueWidth'($urandom_range(2, 6)));
      endcase
      write_cfg(CfgFillValue, rnd64());
      for (int r = 0; r < 2; r++) begin
        int nf, ns;
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(20, Depth) : $urandom_range(0, 6);
        ns = ($urandom_range(0, 9) == 0) ? $urandom_range(20, Depth) : $urandom_range(0, 6);
        queue_sequences(nf, ns, (ph % 2) ? 3 : 12);
      end
      // a little unsorted noise
      if (ph == 1) begin
        queue_item(mk(OpAppendFirst, 63'd40, rnd64()));
        queue_item(mk(OpAppendFirst, 63'd10, rnd64()));
        queue_item(mk(OpAppendSecond, 63'd30, rnd64()));
        queue_item(mk(OpAppendSecond, 63'd2, rnd64()));
        queue_item(mk(OpRun, '0, '0));
      end
      wait_idle();
    end

    drain_mode = 1;
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tsa_pkg.sv
hw/rtl/timestamp_sequence_aligner.sv
bench/tb_top.sv
